/* hw/rtl/iitd_pkg.sv */
// Package for the I2C motion sensor transaction decoder.
// Holds the bus event codes, report kinds, register map constants and payload types.
// Has no dependencies; every other file of the block uses it.
package iitd_pkg;

	typedef enum logic [2:0] {
		OP_START   = 3'd0,
		OP_RSTART  = 3'd1,
		OP_STOP    = 3'd2,
		OP_ADDR_WR = 3'd3,
		OP_ADDR_RD = 3'd4,
		OP_DATA_WR = 3'd5,
		OP_DATA_RD = 3'd6,
		OP_OTHER   = 3'd7
	} op_t;

	typedef enum logic [3:0] {
		KIND_NONE      = 4'd0,
		KIND_FOREIGN   = 4'd1,
		KIND_GYRO_CFG  = 4'd2,
		KIND_ACCEL_CFG = 4'd3,
		KIND_INT_EN    = 4'd4,
		KIND_POWER     = 4'd5,
		KIND_WHO_AM_I  = 4'd6,
		KIND_HIGH_BYTE = 4'd7,
		KIND_ACCEL     = 4'd8,
		KIND_TEMP      = 4'd9,
		KIND_GYRO      = 4'd10,
		KIND_RESERVED  = 4'd11
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_SLAVE   = 2'd1,
		PH_POINTER = 2'd2,
		PH_WRITE   = 2'd3
	} phase_t;

	localparam logic [6:0] DEVICE_ADDR_RESET = 7'h68;
	localparam logic [7:0] IGNORED_ADDR      = 8'h7F;
	localparam logic [7:0] REG_GYRO_CFG      = 8'h1B;
	localparam logic [7:0] REG_ACCEL_CFG     = 8'h1C;
	localparam logic [7:0] REG_INT_EN        = 8'h38;
	localparam logic [7:0] REG_POWER         = 8'h6B;
	localparam logic [7:0] REG_WHO_AM_I      = 8'h75;
	localparam logic [7:0] DATA_FIRST        = 8'h3B;
	localparam logic [7:0] DATA_LAST         = 8'h48;

	localparam int         CHANNELS   = 7;
	localparam logic [2:0] CH_TEMP    = 3'd3;
	localparam logic [2:0] CH_GYRO_X  = 3'd4;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		kind_t              event_kind;
		logic [7:0]         register_address;
		logic [7:0]         byte_seen;
		logic [1:0]         axis;
		logic signed [15:0] sample_value;
		logic               is_register_write;
		logic [2:0]         self_test_bits;
		logic [1:0]         full_scale;
		logic [2:0]         clock_select;
		logic [3:0]         power_flags;
		logic [2:0]         interrupt_flags;
	} out_item_t;

	typedef struct packed {
		out_item_t  item;
		logic       data_reg;
		logic       high_byte;
		logic [2:0] channel;
	} dec_t;

endpackage

/* hw/rtl/iitd_if.sv */
// Valid/ready channel interfaces for the transaction decoder.
// The input channel carries bus events and the output channel carries reports.
// Depends on iitd_pkg for the payload types.
interface iitd_in_if;
	logic              valid;
	logic              ready;
	iitd_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface iitd_out_if;
	logic                valid;
	logic                ready;
	iitd_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* hw/rtl/iitd_decode.sv */
// Register decoder: turns one data byte and the register pointer into a report.
// Also tells whether the register lies in the sample block and which channel it feeds.
// Depends on iitd_pkg.
module iitd_decode (
	input  logic [7:0]      pointer,
	input  logic [7:0]      data_byte,
	input  logic            is_write,
	input  logic [7:0]      high_byte,
	output logic [2:0]      sample_channel,
	output iitd_pkg::dec_t  dec
);

	logic [7:0] offset;
	logic [2:0] channel;
	logic [2:0] gyro_axis;

	assign offset    = pointer - iitd_pkg::DATA_FIRST;
	assign channel   = offset[3:1];
	assign gyro_axis = channel - iitd_pkg::CH_GYRO_X;

	assign sample_channel = ((pointer >= iitd_pkg::DATA_FIRST) &&
		(pointer <= iitd_pkg::DATA_LAST)) ? channel : 3'd0;

	always_comb begin
		dec                        = '0;
		dec.item.event_kind        = iitd_pkg::KIND_RESERVED;
		dec.item.register_address  = pointer;
		dec.item.byte_seen         = data_byte;
		dec.item.is_register_write = is_write;
		unique case (pointer) inside
			iitd_pkg::REG_GYRO_CFG, iitd_pkg::REG_ACCEL_CFG: begin
				dec.item.event_kind     = (pointer == iitd_pkg::REG_GYRO_CFG) ?
					iitd_pkg::KIND_GYRO_CFG : iitd_pkg::KIND_ACCEL_CFG;
				dec.item.self_test_bits = data_byte[7:5];
				dec.item.full_scale     = data_byte[4:3];
			end
			iitd_pkg::REG_INT_EN: begin
				dec.item.event_kind      = iitd_pkg::KIND_INT_EN;
				dec.item.interrupt_flags = {data_byte[4], data_byte[3], data_byte[0]};
			end
			iitd_pkg::REG_POWER: begin
				dec.item.event_kind   = iitd_pkg::KIND_POWER;
				dec.item.clock_select = data_byte[2:0];
				dec.item.power_flags  = {data_byte[7], data_byte[6], data_byte[5],
					data_byte[3]};
			end
			iitd_pkg::REG_WHO_AM_I: begin
				dec.item.event_kind = iitd_pkg::KIND_WHO_AM_I;
			end
			[iitd_pkg::DATA_FIRST:iitd_pkg::DATA_LAST]: begin
				dec.data_reg = 1'b1;
				dec.channel  = channel;
				if (!offset[0]) begin
					dec.high_byte       = 1'b1;
					dec.item.event_kind = iitd_pkg::KIND_HIGH_BYTE;
				end else begin
					dec.item.sample_value = {high_byte, data_byte};
					if (channel < iitd_pkg::CH_TEMP) begin
						dec.item.event_kind = iitd_pkg::KIND_ACCEL;
						dec.item.axis       = channel[1:0];
					end else if (channel == iitd_pkg::CH_TEMP) begin
						dec.item.event_kind = iitd_pkg::KIND_TEMP;
					end else begin
						dec.item.event_kind = iitd_pkg::KIND_GYRO;
						dec.item.axis       = gyro_axis[1:0];
					end
				end
			end
			default: begin
				dec.item.event_kind = iitd_pkg::KIND_RESERVED;
			end
		endcase
	end

endmodule

/* hw/rtl/i2c_imu_transaction_decoder_unit.sv */
// Top level of the I2C motion sensor transaction decoder.
// Depends on iitd_pkg, the channel interfaces in iitd_if.sv and iitd_decode.
//
//   Port      Direction  Handshake     Content
//   in_ch     sink       valid/ready   bus event: operation, data_byte
//   out_ch    source     valid/ready   one report per decoded data byte or foreign address
//   cfg_we    input      write enable  device_address taken from cfg_wdata
//
// An event is registered on acceptance and decoded from the input register into the result
// register; one event is taken every cycle while no stalled report holds the input
// register. Phase, register pointer and the seven stored high bytes update as the
// event leaves the input register. Reset clears phase, pointer, high bytes and both
// valid flags and loads address 0x68. A stalled report holds the input register;
// events that produce no report still pass through while the result register is free.
module i2c_imu_transaction_decoder_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata,
	iitd_in_if.sink           in_ch,
	iitd_out_if.source        out_ch
);

	iitd_pkg::in_item_t  item_s1;
	logic                valid_s1;
	iitd_pkg::out_item_t result_q;
	logic                result_valid_q;

	logic [6:0]          device_address_q;
	iitd_pkg::phase_t    phase_q;
	iitd_pkg::phase_t    phase_d;
	logic [7:0]          pointer_q;
	logic [7:0]          high_q [iitd_pkg::CHANNELS];

	logic                advance;
	logic                addr_event;
	logic                addr_match;
	logic                do_decode;
	logic                has_result;
	logic                load_pointer;
	logic [2:0]          sample_channel;
	iitd_pkg::out_item_t result_d;
	iitd_pkg::dec_t      dec;

	assign advance      = valid_s1 && (!result_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = result_valid_q;
	assign out_ch.payload = result_q;

	assign addr_event = (item_s1.operation == iitd_pkg::OP_ADDR_WR) ||
		(item_s1.operation == iitd_pkg::OP_ADDR_RD);
	assign addr_match = item_s1.data_byte == {1'b0, device_address_q};

	iitd_decode u_decode (
		.pointer        (pointer_q),
		.data_byte      (item_s1.data_byte),
		.is_write       (phase_q == iitd_pkg::PH_WRITE),
		.high_byte      (high_q[sample_channel]),
		.sample_channel (sample_channel),
		.dec            (dec)
	);

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			iitd_pkg::PH_IDLE: begin
				if (item_s1.operation == iitd_pkg::OP_START) begin
					phase_d = iitd_pkg::PH_SLAVE;
				end
			end
			iitd_pkg::PH_SLAVE: begin
				if (addr_event) begin
					phase_d = addr_match ? iitd_pkg::PH_POINTER : iitd_pkg::PH_IDLE;
				end
			end
			iitd_pkg::PH_POINTER: begin
				if (item_s1.operation == iitd_pkg::OP_RSTART) begin
					phase_d = iitd_pkg::PH_SLAVE;
				end else if (item_s1.operation == iitd_pkg::OP_STOP) begin
					phase_d = iitd_pkg::PH_IDLE;
				end else if (item_s1.operation == iitd_pkg::OP_DATA_WR) begin
					phase_d = iitd_pkg::PH_WRITE;
				end
			end
			iitd_pkg::PH_WRITE: begin
				if (item_s1.operation == iitd_pkg::OP_STOP) begin
					phase_d = iitd_pkg::PH_IDLE;
				end else if (item_s1.operation == iitd_pkg::OP_RSTART) begin
					phase_d = iitd_pkg::PH_SLAVE;
				end
			end
			default: begin
				phase_d = iitd_pkg::PH_IDLE;
			end
		endcase
	end

	always_comb begin
		has_result   = 1'b0;
		do_decode    = 1'b0;
		load_pointer = 1'b0;
		result_d     = dec.item;
		unique case (phase_q)
			iitd_pkg::PH_IDLE: begin
				has_result = 1'b0;
			end
			iitd_pkg::PH_SLAVE: begin
				if (addr_event && !addr_match &&
					item_s1.data_byte != iitd_pkg::IGNORED_ADDR) begin
					has_result          = 1'b1;
					result_d            = '0;
					result_d.event_kind = iitd_pkg::KIND_FOREIGN;
					result_d.byte_seen  = item_s1.data_byte;
				end
			end
			iitd_pkg::PH_POINTER: begin
				load_pointer = item_s1.operation == iitd_pkg::OP_DATA_WR;
				do_decode    = item_s1.operation == iitd_pkg::OP_DATA_RD;
				has_result   = do_decode;
			end
			iitd_pkg::PH_WRITE: begin
				do_decode  = item_s1.operation == iitd_pkg::OP_DATA_WR;
				has_result = do_decode;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			item_s1 <= in_ch.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= has_result;
		end else if (out_ch.ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			result_q <= result_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= iitd_pkg::DEVICE_ADDR_RESET;
		end else if (cfg_we) begin
			device_address_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= iitd_pkg::PH_IDLE;
			pointer_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (load_pointer) begin
				pointer_q <= item_s1.data_byte;
			end else if (do_decode && dec.data_reg) begin
				pointer_q <= pointer_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iitd_pkg::CHANNELS; i++) begin
				high_q[i] <= '0;
			end
		end else if (advance && do_decode && dec.high_byte) begin
			high_q[dec.channel] <= item_s1.data_byte;
		end
	end

endmodule
